// ----- src/ffpa_pkg.sv -----
// Shared types and constants for the first-fit pool allocator.
// No dependencies; imported by ffpa_alu, the allocator and the bench.
package ffpa_pkg;

	localparam int POOL_BYTES   = 1024;
	localparam int HEADER_BYTES = 24;

	localparam int REQ_W  = 11;
	localparam int OFF_W  = 10;
	localparam int POS_W  = $clog2(POOL_BYTES);
	localparam int SZ_W   = $clog2(POOL_BYTES);
	localparam int CALC_W = ((POS_W > REQ_W) ? POS_W : REQ_W) + 2;

	localparam logic [CALC_W-1:0] HDR_C  = CALC_W'(HEADER_BYTES);
	localparam logic [CALC_W-1:0] POOL_C = CALC_W'(POOL_BYTES);

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;
	localparam logic ST_DONE     = 1'b0;
	localparam logic ST_NOSPACE  = 1'b1;

	typedef struct packed {
		logic             action;
		logic [REQ_W-1:0] request_size;
		logic [OFF_W-1:0] release_offset;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [OFF_W-1:0] granted_offset;
		logic             was_split;
	} rsp_t;

	typedef struct packed {
		logic            free;
		logic [SZ_W-1:0] size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	localparam hdr_t RST_HDR = '{free: 1'b1, size: SZ_W'(POOL_BYTES - HEADER_BYTES)};

	// Operands for the shared adder/compare unit.
	typedef struct packed {
		logic [CALC_W-1:0] a1;
		logic [CALC_W-1:0] b1;
		logic [CALC_W-1:0] a2;
		logic [CALC_W-1:0] b2;
		logic [CALC_W-1:0] c;
		logic [CALC_W-1:0] d;
	} alu_in_t;

	typedef struct packed {
		logic [CALC_W-1:0] s1;
		logic [CALC_W-1:0] s2;
		logic signed [CALC_W:0] diff;
		logic              ge;
	} alu_out_t;

endpackage

// ----- src/ffpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/ffpa_alu.sv -----
// Shared arithmetic unit: two header-offset adders and a fit/remainder compare.
// Depends on ffpa_pkg.
module ffpa_alu (
	input  ffpa_pkg::alu_in_t  op,
	output ffpa_pkg::alu_out_t res
);
	import ffpa_pkg::*;

	// Sums include one header; diff is the remainder after a split.
	always_comb begin
		res.s1   = op.a1 + op.b1 + HDR_C;
		res.s2   = op.a2 + op.b2 + HDR_C;
		res.diff = $signed({1'b0, op.c}) - $signed({1'b0, op.d}) - $signed({1'b0, HDR_C});
		res.ge   = (op.c >= op.d);
	end

endmodule

// ----- src/first_fit_pool_allocator.sv -----
// First-fit pool allocator: header chain in RAM, one chain step per cycle (one read port).
// Allocate walks the chain until a block fits or the chain ends, plus a split step on a split;
// release walks to the target block, then makes a merge pass over the whole chain, and
// finishes early when no block matches or the offset is below the first data offset. One item at a
// time: next transfer in the cycle after the result loads, held while the last result waits.
// Async reset clears control state; header 0 reads as the full free pool until first written.
module first_fit_pool_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ffpa_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffpa_pkg::rsp_t rsp_data
);
	import ffpa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_WALK  = 8'b0000_0010,  // allocate: first-fit search
		S_SPLIT = 8'b0000_0100,  // allocate: shrink found block after split
		S_FIND  = 8'b0000_1000,  // release: locate block by data offset
		S_MRD   = 8'b0001_0000,  // merge: fetch chain head
		S_MCUR  = 8'b0010_0000,  // merge: examine current block
		S_MNXT  = 8'b0100_0000,  // merge: examine right neighbor of free block
		S_FIN   = 8'b1000_0000   // hand result to output register
	} state_t;

	state_t            state_q, state_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [POS_W-1:0]  nxt_q, nxt_d;
	logic [SZ_W-1:0]   cur_q, cur_d;
	logic [REQ_W-1:0]  req_q;
	logic [OFF_W-1:0]  off_q;
	rsp_t              res_q, res_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic              init_q;
	logic              rd_zero_q;
	logic              load_rsp;

	logic              rd_en, wr_en;
	logic [POS_W-1:0]  rd_addr, wr_addr;
	hdr_t              wr_data;
	logic [HDR_W-1:0]  ram_rdata;
	hdr_t              ent;

	alu_in_t           alu_op;
	alu_out_t          alu_res;

	ffpa_ram #(
		.WIDTH (HDR_W),
		.DEPTH (POOL_BYTES)
	) u_hdr_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	ffpa_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	// Serve the reset header at offset zero until the first write lands there.
	// Every other entry is written (split remainder) before the chain reaches it.
	assign ent = (rd_zero_q && !init_q) ? RST_HDR : hdr_t'(ram_rdata);

	// Route operands to the shared unit by state.
	always_comb begin
		alu_op.a1 = (state_q == S_MNXT) ? CALC_W'(nxt_q) : CALC_W'(pos_q);
		alu_op.b1 = CALC_W'(ent.size);
		alu_op.a2 = (state_q == S_MNXT) ? CALC_W'(cur_q) : CALC_W'(pos_q);
		case (state_q)
			S_WALK:  alu_op.b2 = CALC_W'(req_q);
			S_FIND:  alu_op.b2 = '0;
			default: alu_op.b2 = CALC_W'(ent.size);
		endcase
		alu_op.c = CALC_W'(ent.size);
		alu_op.d = CALC_W'(req_q);
	end

	assign req_ready = (state_q == S_IDLE);

	// Sequencer: one chain step per cycle, next read issued as soon as its
	// address is known.
	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		nxt_d    = nxt_q;
		cur_d    = cur_q;
		res_d    = res_q;
		rd_en    = 1'b0;
		rd_addr  = pos_q;
		wr_en    = 1'b0;
		wr_addr  = pos_q;
		wr_data  = ent;
		load_rsp = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					pos_d = '0;
					res_d = '0;
					if (req_data.action == ACT_ALLOC) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = S_WALK;
					end else if (CALC_W'(req_data.release_offset) < HDR_C) begin
						state_d = S_FIN;
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = S_FIND;
					end
				end
			end
			S_WALK: begin
				if (ent.free && alu_res.ge) begin
					res_d.status         = ST_DONE;
					res_d.granted_offset = OFF_W'(CALC_W'(pos_q) + HDR_C);
					if (alu_res.diff > 0) begin
						// Carve the remainder first, shrink the found block next.
						wr_en           = 1'b1;
						wr_addr         = POS_W'(alu_res.s2);
						wr_data.free    = 1'b1;
						wr_data.size    = SZ_W'(alu_res.diff);
						res_d.was_split = 1'b1;
						state_d         = S_SPLIT;
					end else begin
						wr_en        = 1'b1;
						wr_data.free = 1'b0;
						state_d      = S_FIN;
					end
				end else if (alu_res.s1 >= POOL_C) begin
					res_d.status = ST_NOSPACE;
					state_d      = S_FIN;
				end else begin
					pos_d   = POS_W'(alu_res.s1);
					rd_en   = 1'b1;
					rd_addr = POS_W'(alu_res.s1);
				end
			end
			S_SPLIT: begin
				wr_en        = 1'b1;
				wr_data.free = 1'b0;
				wr_data.size = SZ_W'(req_q);
				state_d      = S_FIN;
			end
			S_FIND: begin
				if (alu_res.s2 == CALC_W'(off_q)) begin
					wr_en        = 1'b1;
					wr_data.free = 1'b1;
					pos_d        = '0;
					state_d      = S_MRD;
				end else if (alu_res.s2 > CALC_W'(off_q) || alu_res.s1 >= POOL_C) begin
					// Drop: offset is not the data area of any block.
					state_d = S_FIN;
				end else begin
					pos_d   = POS_W'(alu_res.s1);
					rd_en   = 1'b1;
					rd_addr = POS_W'(alu_res.s1);
				end
			end
			S_MRD: begin
				rd_en   = 1'b1;
				rd_addr = pos_q;
				state_d = S_MCUR;
			end
			S_MCUR: begin
				if (alu_res.s1 >= POOL_C) begin
					state_d = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = POS_W'(alu_res.s1);
					if (ent.free) begin
						cur_d   = ent.size;
						nxt_d   = POS_W'(alu_res.s1);
						state_d = S_MNXT;
					end else begin
						pos_d = POS_W'(alu_res.s1);
					end
				end
			end
			S_MNXT: begin
				if (ent.free) begin
					// Absorb the neighbor; the run may go on.
					wr_en        = 1'b1;
					wr_data.free = 1'b1;
					wr_data.size = SZ_W'(alu_res.s2);
					cur_d        = SZ_W'(alu_res.s2);
					nxt_d        = POS_W'(alu_res.s1);
					if (alu_res.s1 >= POOL_C) begin
						state_d = S_FIN;
					end else begin
						rd_en   = 1'b1;
						rd_addr = POS_W'(alu_res.s1);
					end
				end else if (alu_res.s1 >= POOL_C) begin
					state_d = S_FIN;
				end else begin
					// Neighbor is taken: skip it and resume after it.
					pos_d   = POS_W'(alu_res.s1);
					rd_en   = 1'b1;
					rd_addr = POS_W'(alu_res.s1);
					state_d = S_MCUR;
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			init_q      <= 1'b0;
			rd_zero_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (wr_en && wr_addr == '0) begin
				init_q <= 1'b1;
			end
			if (rd_en) begin
				rd_zero_q <= (rd_addr == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		nxt_q <= nxt_d;
		cur_q <= cur_d;
		res_q <= res_d;
		if (req_valid && req_ready) begin
			req_q <= req_data.request_size;
			off_q <= req_data.release_offset;
		end
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en && rd_addr == wr_addr))
		else $error("header read and write hit the same entry");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_NOSPACE |->
			rsp_data.granted_offset == '0 && !rsp_data.was_split)
		else $error("no-space result carries an offset or split flag");

	a_split_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPLIT |-> $past(state_q) == S_WALK)
		else $error("split step entered outside an allocation walk");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == S_FIN)
		else $error("result raised without finishing an item");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for first_fit_pool_allocator: first-fit allocate, split, release, coalesce.
// Depends on ffpa_pkg and the block's RTL. Responses are checked in order against a built-in
// model of the header chain.
`timescale 1ns / 1ps

module testbench;
	import ffpa_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int LONG_STALL   = 400;
	localparam int TAIL_CYCLES  = 200;
	localparam int MAX_REPORTED = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// Model of the header chain: one entry per pool byte, only chain heads matter.
	logic [SZ_W-1:0] blk_size [POOL_BYTES];
	logic            blk_free [POOL_BYTES];

	// Responses predicted at request acceptance, oldest first.
	rsp_t predicted_rsp[$];

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	logic stall_trigger = 1'b0;
	logic stall_seen = 1'b0;
	int stall_left = 0;

	int cycle_count    = 0;
	int mismatch_count = 0;
	int checked_count  = 0;
	int n_alloc = 0, n_split = 0, n_nospace = 0, n_release = 0;

	first_fit_pool_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, predicted_rsp.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Merge every run of adjacent free blocks, however long the run is.
	function automatic void coalesce_free_runs();
		int pos;
		int nxt;
		pos = 0;
		while (pos < POOL_BYTES) begin
			nxt = pos + HEADER_BYTES + int'(blk_size[pos]);
			while (blk_free[pos] && nxt < POOL_BYTES && blk_free[nxt]) begin
				blk_size[pos] = SZ_W'(int'(blk_size[pos]) + HEADER_BYTES
					+ int'(blk_size[nxt]));
				nxt = pos + HEADER_BYTES + int'(blk_size[pos]);
			end
			pos = nxt;
		end
	endfunction

	// Apply one request to the chain model and return the response it must produce.
	function automatic rsp_t predict_pool_op(req_t item);
		rsp_t r;
		int pos;
		int req;
		int off;
		int sz;
		r = '0;
		r.status = ST_DONE;
		pos = 0;
		if (item.action == ACT_ALLOC) begin
			req = int'(item.request_size);
			r.status = ST_NOSPACE;
			while (pos < POOL_BYTES) begin
				sz = int'(blk_size[pos]);
				if (blk_free[pos] && sz >= req) begin
					// split only when the leftover can hold a header and more
					if (sz > req + HEADER_BYTES) begin
						blk_size[pos + HEADER_BYTES + req] = SZ_W'(sz - req - HEADER_BYTES);
						blk_free[pos + HEADER_BYTES + req] = 1'b1;
						blk_size[pos] = SZ_W'(req);
						r.was_split = 1'b1;
					end
					blk_free[pos] = 1'b0;
					r.status = ST_DONE;
					r.granted_offset = OFF_W'(pos + HEADER_BYTES);
					break;
				end
				pos += HEADER_BYTES + sz;
			end
		end else begin
			off = int'(item.release_offset);
			// offsets that hit no data area are dropped silently
			if (off >= HEADER_BYTES) begin
				while (pos < POOL_BYTES && pos + HEADER_BYTES <= off) begin
					if (pos + HEADER_BYTES == off) begin
						blk_free[pos] = 1'b1;
						coalesce_free_runs();
						break;
					end
					pos += HEADER_BYTES + int'(blk_size[pos]);
				end
			end
		end
		return r;
	endfunction

	function automatic req_t alloc_op(int bytes);
		req_t item;
		item.action = ACT_ALLOC;
		item.request_size = REQ_W'(bytes);
		item.release_offset = OFF_W'($urandom);
		return item;
	endfunction

	function automatic req_t release_op(int off);
		req_t item;
		item.action = ACT_RELEASE;
		item.request_size = REQ_W'($urandom_range(1024));
		item.release_offset = OFF_W'(off);
		return item;
	endfunction

	// Choose the next request from the current chain: mostly valid releases of
	// live blocks and allocations of random size, some near free-block sizes, plus some noise.
	function automatic req_t pick_pool_op();
		int used_q[$];
		int free_q[$];
		int free_sz[$];
		int pos;
		int roll;
		int pick;
		int s;
		pos = 0;
		while (pos < POOL_BYTES) begin
			if (blk_free[pos]) begin
				free_q.push_back(pos + HEADER_BYTES);
				free_sz.push_back(int'(blk_size[pos]));
			end else begin
				used_q.push_back(pos + HEADER_BYTES);
			end
			pos += HEADER_BYTES + int'(blk_size[pos]);
		end
		roll = $urandom_range(99);
		if (used_q.size() > 0 && roll < ((used_q.size() >= 8) ? 60 : 35)) begin
			roll = $urandom_range(99);
			if (roll < 85)
				return release_op(used_q[$urandom_range(used_q.size() - 1)]);
			if (roll < 93 && free_q.size() > 0)
				return release_op(free_q[$urandom_range(free_q.size() - 1)]);
			return release_op($urandom_range(1023));
		end
		roll = $urandom_range(99);
		if (roll < 55)
			return alloc_op($urandom_range(64));
		if (roll < 78)
			return alloc_op($urandom_range(300));
		if (roll < 88 || free_sz.size() == 0)
			return alloc_op($urandom_range(1024));
		// probe the fit and split boundaries of an existing free block
		s = free_sz[$urandom_range(free_sz.size() - 1)];
		pick = $urandom_range(4);
		case (pick)
			0: s = s + 1;
			1: s = s - HEADER_BYTES;
			2: s = s - HEADER_BYTES - 1;
			3: s = s - HEADER_BYTES + 1;
			default: ;
		endcase
		if (s < 0) s = 0;
		if (s > 1024) s = 1024;
		return alloc_op(s);
	endfunction

	// Offer one request, hold it until accepted, then record its expected response.
	task automatic send_item(input req_t item);
		rsp_t want;
		if ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		do @(posedge clk); while (!req_ready);
		want = predict_pool_op(item);
		predicted_rsp.push_back(want);
		if (item.action == ACT_ALLOC) begin
			n_alloc++;
			if (want.status == ST_NOSPACE) n_nospace++;
			if (want.was_split) n_split++;
		end else begin
			n_release++;
		end
	endtask

	// Drop valid and hold off until every predicted response has been seen.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (predicted_rsp.size() != 0);
	endtask

	task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("%0t: %s: expected status=%0d offset=%0d split=%0d, got status=%0d offset=%0d split=%0d",
				$time, what, want.status, want.granted_offset, want.was_split,
				got.status, got.granted_offset, got.was_split);
	endtask

	// Receiver: random ready, or a long hold-off each time the trigger flips.
	always @(posedge clk) begin
		if (stall_trigger != stall_seen) begin
			stall_seen <= stall_trigger;
			stall_left <= LONG_STALL;
			rsp_ready  <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Check each response transfer against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (predicted_rsp.size() == 0) begin
				note_mismatch("response with nothing pending", '0, rsp_data);
			end else begin
				want = predicted_rsp.pop_front();
				checked_count++;
				if (rsp_data.status != want.status
						|| rsp_data.granted_offset != want.granted_offset
						|| rsp_data.was_split != want.was_split)
					note_mismatch("response mismatch", want, rsp_data);
			end
		end
	end

	// Walk the boundary cases by hand: exact fit, split threshold, zero-size blocks,
	// bad and repeated releases, and a release that closes a three-block free run.
	task automatic test_directed_cases();
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		send_item(alloc_op(1024));
		send_item(alloc_op(POOL_BYTES - HEADER_BYTES));
		send_item(alloc_op(0));
		send_item(release_op(HEADER_BYTES));
		send_item(release_op(HEADER_BYTES));
		send_item(release_op(0));
		send_item(release_op(1023));
		send_item(release_op(HEADER_BYTES + 1));
		send_item(alloc_op(POOL_BYTES - 2 * HEADER_BYTES + 1));
		send_item(release_op(HEADER_BYTES));
		send_item(alloc_op(POOL_BYTES - 2 * HEADER_BYTES));
		send_item(release_op(HEADER_BYTES));
		send_item(alloc_op(POOL_BYTES - 2 * HEADER_BYTES - 1));
		send_item(release_op(HEADER_BYTES));
		send_item(alloc_op(0));
		send_item(alloc_op(0));
		send_item(alloc_op(100));
		send_item(alloc_op(50));
		send_item(release_op(2 * HEADER_BYTES));
		send_item(release_op(4 * HEADER_BYTES + 100));
		send_item(release_op(HEADER_BYTES));
		send_item(release_op(3 * HEADER_BYTES));
		send_item(alloc_op(1024));
		wait_for_drain();
	endtask

	task automatic test_random_mix(input int count, input int snd_pct, input int rcv_pct);
		sender_idle_pct   = snd_pct;
		receiver_idle_pct = rcv_pct;
		repeat (count) send_item(pick_pool_op());
		wait_for_drain();
	endtask

	// Stall the receiver for a long stretch while requests keep coming back to back,
	// so the block backs up and drops req_ready.
	task automatic test_backpressure_fill();
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		stall_trigger <= ~stall_trigger;
		repeat (12) send_item(pick_pool_op());
		wait_for_drain();
	endtask

	initial begin
		foreach (blk_size[i]) begin
			blk_size[i] = '0;
			blk_free[i] = 1'b0;
		end
		blk_size[0] = SZ_W'(POOL_BYTES - HEADER_BYTES);
		blk_free[0] = 1'b1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_mix(300, 31, 57);
		test_backpressure_fill();
		test_random_mix(300, 57, 31);
		test_random_mix(300, 0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d allocations (%0d split, %0d out of space), %0d releases.",
			n_alloc + n_release, n_alloc, n_split, n_nospace, n_release);
		$display("Checked %0d responses under mixed idling and a %0d-cycle receiver stall; %0d mismatches.",
			checked_count, LONG_STALL, mismatch_count);
		if (mismatch_count == 0 && predicted_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
